// ===== design/grid_raycast_column_defines.svh =====
`ifndef GRID_RAYCAST_COLUMN_DEFINES_SVH
`define GRID_RAYCAST_COLUMN_DEFINES_SVH

// same-cycle implication
`define GRC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/grc_pkg.sv =====
package grc_pkg;

   localparam int MAP_BITS   = 6;
   localparam int MAP_DIM    = 1 << MAP_BITS;
   localparam int TEX_BITS   = 6;
   localparam int MAX_STEPS  = 128;
   localparam int STEP_BITS  = 8;
   localparam int POS_W      = 16;
   localparam int FRAC_W     = 10;
   localparam int RD_W       = 28;
   localparam int D_W        = 27;
   localparam int AX_W       = 18;
   localparam int CAM_W      = 27;
   localparam int MUL_W      = 29;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int DIVN_W     = 48;
   localparam int DIVD_W     = 27;
   localparam int DIV_CNT_W  = 6;
   localparam int SIZE_W     = 11;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int CODE_W     = 4;
   localparam int COL_W      = 10;
   localparam int OUT_W      = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_POS_X    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POS_Y    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_X    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_Y    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_X  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_Y  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_W = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_H = 3'd7;

   localparam logic FUNC_MAP_WR = 1'b0;
   localparam logic FUNC_CAST   = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE, ST_CAM_GO, ST_CAM_WAIT, ST_RAY_MUL, ST_RAY_SUM, ST_DDA_INIT,
      ST_DDA_MUL, ST_DDA_STEP, ST_DDA_CHECK, ST_PERP_GO, ST_PERP_WAIT,
      ST_TEX_MUL, ST_TEX_SUM, ST_TEX_GO, ST_TEX_WAIT, ST_LH_GO, ST_LH_WAIT,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {DIV_CAM, DIV_PERP, DIV_TEX, DIV_LH} div_sel_type;
   typedef enum logic [1:0] {MUL_RAY, MUL_DDA, MUL_TEX} mul_sel_type;

   typedef struct packed {
      logic        map_we;
      logic        load_req;
      logic        div_start;
      div_sel_type div_sel;
      mul_sel_type mul_sel;
      logic        cam_load;
      logic        ray_load;
      logic        dda_init;
      logic        dda_step;
      logic        dda_hit;
      logic        perp_load;
      logic        perp_sat;
      logic        tsum_load;
      logic        tex_load;
      logic        lh_load;
      logic        lh_max;
      logic        res_load;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic oob;
      logic code_nz;
      logic steps_done;
      logic d_zero;
      logic perp_zero;
      logic rsp_free;
   } status_type;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
      logic [SIZE_W-1:0] r;
      if (v == '0) r = SIZE_W'(1);
      else if (v > SIZE_W'(1024)) r = SIZE_W'(1024);
      else r = v;
      return r;
   endfunction

endpackage

// ===== design/grc_div.sv =====
module grc_div
   import grc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIVN_W-1:0] dividend,
   input  logic [DIVD_W-1:0] divisor,
   output logic [DIVN_W-1:0] quotient,
   output logic              done
);

   logic [DIVD_W-1:0]    rem_ff, rem_in;
   logic [DIVN_W-1:0]    quo_ff, quo_in;
   logic [DIVD_W-1:0]    dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIVD_W:0]      trial;
   logic [DIVD_W:0]      diff;
   logic                 ge;

   assign trial = {rem_ff, quo_ff[DIVN_W-1]};
   assign ge    = trial >= {1'b0, dvs_ff};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIVD_W-1:0] : trial[DIVD_W-1:0];
         quo_in = {quo_ff[DIVN_W-2:0], ge};
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIVN_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// ===== design/grc_dpath.sv =====
module grc_dpath
   import grc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [MAP_BITS-1:0]   req_cell_x,
   input  logic [MAP_BITS-1:0]   req_cell_y,
   input  logic [CODE_W-1:0]     req_cell_code,
   input  logic [COL_W-1:0]      req_column,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [COL_W-1:0]      rsp_out_column,
   output logic                  rsp_hit,
   output logic                  rsp_side,
   output logic [CODE_W-1:0]     rsp_wall_code,
   output logic [OUT_W-1:0]      rsp_perp_dist,
   output logic [OUT_W-1:0]      rsp_line_height,
   output logic [COL_W-1:0]      rsp_draw_start,
   output logic [COL_W-1:0]      rsp_draw_end,
   output logic [TEX_BITS-1:0]   rsp_tex_x
);

   localparam logic [CAM_W-1:0] CAM_ONE  = CAM_W'(16384);
   localparam logic [AX_W-1:0]  CELL_ONE = AX_W'(1 << FRAC_W);

   logic [CODE_W-1:0] map_mem [MAP_DIM*MAP_DIM];

   logic [POS_W-1:0]  pos_x_ff, pos_y_ff;
   logic [POS_W-1:0]  dir_x_ff, dir_y_ff, plane_x_ff, plane_y_ff;
   logic [SIZE_W-1:0] screen_w_ff, screen_h_ff;

   logic [COL_W-1:0]         col_ff;
   logic signed [CAM_W-1:0]  cam_ff;
   logic signed [PROD_W-1:0] prod0_ff, prod1_ff;
   logic signed [RD_W-1:0]   rdx_ff, rdy_ff;
   logic [AX_W-1:0]          ax_ff, ay_ff, n_ff;
   logic [MAP_BITS-1:0]      mx_ff, my_ff;
   logic                     oob_ff, side_ff, hit_ff;
   logic [STEP_BITS-1:0]     steps_ff;
   logic [CODE_W-1:0]        code_ff, mem_q_ff;
   logic [OUT_W-1:0]         perp_ff, lh_ff;
   logic signed [DIVN_W-1:0] s_ff;
   logic [TEX_BITS-1:0]      tex_ff;

   logic                     rsp_valid_ff;
   logic [COL_W-1:0]         rsp_col_ff, rsp_ds_ff, rsp_de_ff;
   logic                     rsp_hit_ff, rsp_side_ff;
   logic [CODE_W-1:0]        rsp_code_ff;
   logic [OUT_W-1:0]         rsp_perp_ff, rsp_lh_ff;
   logic [TEX_BITS-1:0]      rsp_tex_ff;

   logic [SIZE_W-1:0]        w_eff, h_eff;
   logic [D_W-1:0]           dx, dy, d_sel;
   logic signed [RD_W-1:0]   rd_abs_x, rd_abs_y, other;
   logic signed [MUL_W-1:0]  a0, b0, a1, b1;
   logic [DIVN_W-1:0]        div_n, div_q;
   logic [DIVD_W-1:0]        div_d;
   logic                     div_done;
   logic signed [DIVN_W-1:0] s_shift;
   logic                     step_x;
   logic [MAP_BITS:0]        mx_next, my_next;
   logic [2*MAP_BITS-1:0]    rd_addr;
   logic signed [PROD_W-1:0] ray_x_sum, ray_y_sum;
   logic [POS_W-1:0]         base;
   logic [TEX_BITS-1:0]      tq;
   logic                     mirror;
   logic [SIZE_W-2:0]        half_h;
   logic [OUT_W-2:0]         half_l;
   logic signed [OUT_W:0]    ds_s;
   logic [OUT_W:0]           de_s;
   logic [COL_W-1:0]         ds_v, de_v;

   assign w_eff = clamp_size(screen_w_ff);
   assign h_eff = clamp_size(screen_h_ff);

   assign rd_abs_x = rdx_ff[RD_W-1] ? -rdx_ff : rdx_ff;
   assign rd_abs_y = rdy_ff[RD_W-1] ? -rdy_ff : rdy_ff;
   assign dx       = rd_abs_x[D_W-1:0];
   assign dy       = rd_abs_y[D_W-1:0];
   assign d_sel    = side_ff ? dy : dx;
   assign other    = side_ff ? rdx_ff : rdy_ff;
   assign base     = side_ff ? pos_x_ff : pos_y_ff;

   // shared multiplier pair
   always_comb begin
      case (cmd.mul_sel)
         MUL_RAY: begin
            a0 = MUL_W'(signed'(plane_x_ff));
            b0 = MUL_W'(cam_ff);
            a1 = MUL_W'(signed'(plane_y_ff));
            b1 = MUL_W'(cam_ff);
         end
         MUL_TEX: begin
            a0 = signed'({{(MUL_W-POS_W){1'b0}}, base});
            b0 = signed'({{(MUL_W-D_W){1'b0}}, d_sel});
            a1 = signed'({{(MUL_W-AX_W){1'b0}}, n_ff});
            b1 = MUL_W'(other);
         end
         default: begin
            a0 = signed'({{(MUL_W-AX_W){1'b0}}, ax_ff});
            b0 = signed'({{(MUL_W-D_W){1'b0}}, dy});
            a1 = signed'({{(MUL_W-AX_W){1'b0}}, ay_ff});
            b1 = signed'({{(MUL_W-D_W){1'b0}}, dx});
         end
      endcase
   end

   // shared divider operands
   assign s_shift = s_ff >>> 4;
   always_comb begin
      case (cmd.div_sel)
         DIV_PERP: begin
            div_n = DIVN_W'({n_ff, 12'b0});
            div_d = d_sel;
         end
         DIV_TEX: begin
            div_n = s_ff[DIVN_W-1] ? ~s_shift : s_shift;
            div_d = d_sel;
         end
         DIV_LH: begin
            div_n = DIVN_W'({h_eff, 8'b0});
            div_d = DIVD_W'(perp_ff);
         end
         default: begin
            div_n = DIVN_W'({col_ff, 15'b0});
            div_d = DIVD_W'(w_eff);
         end
      endcase
   end

   grc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_n),
      .divisor  (div_d),
      .quotient (div_q),
      .done     (div_done)
   );

   // grid step
   assign step_x  = prod0_ff < prod1_ff;
   assign mx_next = {1'b0, mx_ff} + (rdx_ff[RD_W-1] ? {(MAP_BITS+1){1'b1}} : (MAP_BITS+1)'(1));
   assign my_next = {1'b0, my_ff} + (rdy_ff[RD_W-1] ? {(MAP_BITS+1){1'b1}} : (MAP_BITS+1)'(1));
   assign rd_addr = step_x ? {my_ff, mx_next[MAP_BITS-1:0]} : {my_next[MAP_BITS-1:0], mx_ff};

   assign ray_x_sum = (prod0_ff >>> 14) + PROD_W'(signed'(dir_x_ff));
   assign ray_y_sum = (prod1_ff >>> 14) + PROD_W'(signed'(dir_y_ff));

   assign tq     = div_q[TEX_BITS-1:0] ^ {TEX_BITS{s_ff[DIVN_W-1]}};
   assign mirror = (!side_ff && !rdx_ff[RD_W-1] && rdx_ff != '0) || (side_ff && rdy_ff[RD_W-1]);

   assign half_h = h_eff[SIZE_W-1:1];
   assign half_l = lh_ff[OUT_W-1:1];
   assign ds_s   = signed'((OUT_W+1)'(half_h)) - signed'((OUT_W+1)'(half_l));
   assign de_s   = (OUT_W+1)'(half_l) + (OUT_W+1)'(half_h);
   assign ds_v   = ds_s[OUT_W] ? '0 : ds_s[COL_W-1:0];
   assign de_v   = (de_s >= (OUT_W+1)'(h_eff)) ? COL_W'(h_eff - SIZE_W'(1)) : de_s[COL_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.map_we) begin
         map_mem[{req_cell_y, req_cell_x}] <= req_cell_code;
      end
      mem_q_ff <= map_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff    <= '0;
         pos_y_ff    <= '0;
         dir_x_ff    <= POS_W'(16384);
         dir_y_ff    <= '0;
         plane_x_ff  <= '0;
         plane_y_ff  <= POS_W'(10813);
         screen_w_ff <= SIZE_W'(320);
         screen_h_ff <= SIZE_W'(240);
      end else if (csr_we) begin
         case (csr_index)
            CSR_POS_X:    pos_x_ff    <= csr_wdata;
            CSR_POS_Y:    pos_y_ff    <= csr_wdata;
            CSR_DIR_X:    dir_x_ff    <= csr_wdata;
            CSR_DIR_Y:    dir_y_ff    <= csr_wdata;
            CSR_PLANE_X:  plane_x_ff  <= csr_wdata;
            CSR_PLANE_Y:  plane_y_ff  <= csr_wdata;
            CSR_SCREEN_W: screen_w_ff <= csr_wdata[SIZE_W-1:0];
            CSR_SCREEN_H: screen_h_ff <= csr_wdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      prod0_ff <= a0 * b0;
      prod1_ff <= a1 * b1;
      if (cmd.load_req) col_ff <= req_column;
      if (cmd.cam_load) cam_ff <= signed'(div_q[CAM_W-1:0] - CAM_ONE);
      if (cmd.ray_load) begin
         rdx_ff <= ray_x_sum[RD_W-1:0];
         rdy_ff <= ray_y_sum[RD_W-1:0];
      end
      if (cmd.dda_init) begin
         ax_ff <= rdx_ff[RD_W-1] ? AX_W'(pos_x_ff[FRAC_W-1:0])
                                 : CELL_ONE - AX_W'(pos_x_ff[FRAC_W-1:0]);
         ay_ff <= rdy_ff[RD_W-1] ? AX_W'(pos_y_ff[FRAC_W-1:0])
                                 : CELL_ONE - AX_W'(pos_y_ff[FRAC_W-1:0]);
         mx_ff    <= pos_x_ff[POS_W-1:FRAC_W];
         my_ff    <= pos_y_ff[POS_W-1:FRAC_W];
         n_ff     <= '0;
         side_ff  <= 1'b0;
         oob_ff   <= 1'b0;
         hit_ff   <= 1'b0;
         code_ff  <= '0;
         steps_ff <= '0;
      end else if (cmd.dda_step) begin
         steps_ff <= steps_ff + STEP_BITS'(1);
         if (step_x) begin
            n_ff    <= ax_ff;
            ax_ff   <= ax_ff + CELL_ONE;
            mx_ff   <= mx_next[MAP_BITS-1:0];
            oob_ff  <= mx_next[MAP_BITS];
            side_ff <= 1'b0;
         end else begin
            n_ff    <= ay_ff;
            ay_ff   <= ay_ff + CELL_ONE;
            my_ff   <= my_next[MAP_BITS-1:0];
            oob_ff  <= my_next[MAP_BITS];
            side_ff <= 1'b1;
         end
      end else if (cmd.dda_hit) begin
         hit_ff  <= 1'b1;
         code_ff <= mem_q_ff;
      end
      if (cmd.perp_sat) begin
         perp_ff <= '1;
         tex_ff  <= '0;
      end else if (cmd.perp_load) begin
         perp_ff <= (|div_q[DIVN_W-1:OUT_W]) ? '1 : div_q[OUT_W-1:0];
      end
      if (cmd.tsum_load) s_ff <= prod0_ff[DIVN_W-1:0] + prod1_ff[DIVN_W-1:0];
      if (cmd.tex_load) tex_ff <= mirror ? ~tq : tq;
      if (cmd.lh_max) begin
         lh_ff <= '1;
      end else if (cmd.lh_load) begin
         lh_ff <= (|div_q[DIVN_W-1:OUT_W]) ? '1 : div_q[OUT_W-1:0];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.res_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.res_load) begin
         rsp_col_ff  <= col_ff;
         rsp_hit_ff  <= hit_ff;
         rsp_side_ff <= hit_ff & side_ff;
         rsp_code_ff <= hit_ff ? code_ff : '0;
         rsp_perp_ff <= hit_ff ? perp_ff : '0;
         rsp_lh_ff   <= hit_ff ? lh_ff : '0;
         rsp_ds_ff   <= hit_ff ? ds_v : '0;
         rsp_de_ff   <= hit_ff ? de_v : '0;
         rsp_tex_ff  <= hit_ff ? tex_ff : '0;
      end
   end

   assign status.div_done   = div_done;
   assign status.oob        = oob_ff;
   assign status.code_nz    = mem_q_ff != '0;
   assign status.steps_done = steps_ff == STEP_BITS'(MAX_STEPS);
   assign status.d_zero     = d_sel == '0;
   assign status.perp_zero  = perp_ff == '0;
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_column  = rsp_col_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_side        = rsp_side_ff;
   assign rsp_wall_code   = rsp_code_ff;
   assign rsp_perp_dist   = rsp_perp_ff;
   assign rsp_line_height = rsp_lh_ff;
   assign rsp_draw_start  = rsp_ds_ff;
   assign rsp_draw_end    = rsp_de_ff;
   assign rsp_tex_x       = rsp_tex_ff;

endmodule

// ===== design/grc_ctrl.sv =====
module grc_ctrl
   import grc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_func,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.div_sel = DIV_CAM;
      cmd.mul_sel = MUL_DDA;
      req_ready   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_func == FUNC_CAST) begin
                  cmd.load_req = 1'b1;
                  state_in     = ST_CAM_GO;
               end else begin
                  cmd.map_we = 1'b1;
               end
            end
         end
         ST_CAM_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_CAM_WAIT;
         end
         ST_CAM_WAIT: begin
            if (status.div_done) begin
               cmd.cam_load = 1'b1;
               state_in     = ST_RAY_MUL;
            end
         end
         ST_RAY_MUL: begin
            cmd.mul_sel = MUL_RAY;
            state_in    = ST_RAY_SUM;
         end
         ST_RAY_SUM: begin
            cmd.ray_load = 1'b1;
            state_in     = ST_DDA_INIT;
         end
         ST_DDA_INIT: begin
            cmd.dda_init = 1'b1;
            state_in     = ST_DDA_MUL;
         end
         ST_DDA_MUL: begin
            state_in = ST_DDA_STEP;
         end
         ST_DDA_STEP: begin
            cmd.dda_step = 1'b1;
            state_in     = ST_DDA_CHECK;
         end
         ST_DDA_CHECK: begin
            if (status.oob) begin
               state_in = ST_FINISH;
            end else if (status.code_nz) begin
               cmd.dda_hit = 1'b1;
               state_in    = ST_PERP_GO;
            end else if (status.steps_done) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_DDA_MUL;
            end
         end
         ST_PERP_GO: begin
            cmd.div_sel = DIV_PERP;
            if (status.d_zero) begin
               cmd.perp_sat = 1'b1;
               state_in     = ST_LH_GO;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_PERP_WAIT;
            end
         end
         ST_PERP_WAIT: begin
            if (status.div_done) begin
               cmd.perp_load = 1'b1;
               state_in      = ST_TEX_MUL;
            end
         end
         ST_TEX_MUL: begin
            cmd.mul_sel = MUL_TEX;
            state_in    = ST_TEX_SUM;
         end
         ST_TEX_SUM: begin
            cmd.tsum_load = 1'b1;
            state_in      = ST_TEX_GO;
         end
         ST_TEX_GO: begin
            cmd.div_sel   = DIV_TEX;
            cmd.div_start = 1'b1;
            state_in      = ST_TEX_WAIT;
         end
         ST_TEX_WAIT: begin
            if (status.div_done) begin
               cmd.tex_load = 1'b1;
               state_in     = ST_LH_GO;
            end
         end
         ST_LH_GO: begin
            cmd.div_sel = DIV_LH;
            if (status.perp_zero) begin
               cmd.lh_max = 1'b1;
               state_in   = ST_FINISH;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_LH_WAIT;
            end
         end
         ST_LH_WAIT: begin
            if (status.div_done) begin
               cmd.lh_load = 1'b1;
               state_in    = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.res_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== design/grid_raycast_column.sv =====
// map write: no result; the block is ready again the next cycle
// cast: a camera division, ray setup and one grid step after another,
// then up to three more divisions on the one shared divider; it takes
// longer while an earlier result is still unread in the output register
// reset: control state and the camera and screen registers return to defaults
// map contents are undefined after reset until written, with no clearing pass
module grid_raycast_column
   import grc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_func,
   input  logic [MAP_BITS-1:0]   req_cell_x,
   input  logic [MAP_BITS-1:0]   req_cell_y,
   input  logic [CODE_W-1:0]     req_cell_code,
   input  logic [COL_W-1:0]      req_column,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COL_W-1:0]      rsp_out_column,
   output logic                  rsp_hit,
   output logic                  rsp_side,
   output logic [CODE_W-1:0]     rsp_wall_code,
   output logic [OUT_W-1:0]      rsp_perp_dist,
   output logic [OUT_W-1:0]      rsp_line_height,
   output logic [COL_W-1:0]      rsp_draw_start,
   output logic [COL_W-1:0]      rsp_draw_end,
   output logic [TEX_BITS-1:0]   rsp_tex_x,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   grc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   grc_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_cell_x      (req_cell_x),
      .req_cell_y      (req_cell_y),
      .req_cell_code   (req_cell_code),
      .req_column      (req_column),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_out_column  (rsp_out_column),
      .rsp_hit         (rsp_hit),
      .rsp_side        (rsp_side),
      .rsp_wall_code   (rsp_wall_code),
      .rsp_perp_dist   (rsp_perp_dist),
      .rsp_line_height (rsp_line_height),
      .rsp_draw_start  (rsp_draw_start),
      .rsp_draw_end    (rsp_draw_end),
      .rsp_tex_x       (rsp_tex_x)
   );

endmodule

// ===== design/grc_checker.sv =====
`include "grid_raycast_column_defines.svh"

module grc_checker
   import grc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  req_func,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [COL_W-1:0]      rsp_out_column,
   input logic                  rsp_hit,
   input logic [CODE_W-1:0]     rsp_wall_code,
   input logic [OUT_W-1:0]      rsp_perp_dist,
   input logic [COL_W-1:0]      rsp_draw_start,
   input logic [COL_W-1:0]      rsp_draw_end
);

   `GRC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_column) && $stable(rsp_perp_dist), "stalled result transfer changed")
   `GRC_ASSERT_NEXT(a_cast_busy, clock, reset, req_valid && req_ready && req_func == FUNC_CAST, !req_ready, "ready after cast transfer")
   `GRC_ASSERT_NOW(a_hit_code, clock, reset, rsp_valid && rsp_hit, rsp_wall_code != '0, "hit with empty cell code")
   `GRC_ASSERT_NOW(a_span_order, clock, reset, rsp_valid && rsp_hit, rsp_draw_start <= rsp_draw_end, "draw span reversed")

endmodule

bind grid_raycast_column grc_checker u_checker (.*);

// ===== dv/tb_grid_raycast_column.sv =====
module tb_grid_raycast_column;
   import grc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // walled room in the map corner: cells below ROOM are open, row and column ROOM are walls
   localparam int ROOM = 12;

   typedef struct packed {
      logic [COL_W-1:0]    column;
      logic                hit;
      logic                side;
      logic [CODE_W-1:0]   code;
      logic [OUT_W-1:0]    perp;
      logic [OUT_W-1:0]    height;
      logic [COL_W-1:0]    span_top;
      logic [COL_W-1:0]    span_bottom;
      logic [TEX_BITS-1:0] tex;
   } wall_slice_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_func = FUNC_MAP_WR;
   logic [MAP_BITS-1:0]   req_cell_x = '0;
   logic [MAP_BITS-1:0]   req_cell_y = '0;
   logic [CODE_W-1:0]     req_cell_code = '0;
   logic [COL_W-1:0]      req_column = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [COL_W-1:0]      rsp_out_column;
   logic                  rsp_hit;
   logic                  rsp_side;
   logic [CODE_W-1:0]     rsp_wall_code;
   logic [OUT_W-1:0]      rsp_perp_dist;
   logic [OUT_W-1:0]      rsp_line_height;
   logic [COL_W-1:0]      rsp_draw_start;
   logic [COL_W-1:0]      rsp_draw_end;
   logic [TEX_BITS-1:0]   rsp_tex_x;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   grid_raycast_column dut (.*);

   always #2 clock = ~clock;

   // predictor state
   logic [CODE_W-1:0] grid [MAP_DIM*MAP_DIM];
   logic [15:0]       cam_px, cam_py, cam_dx, cam_dy, cam_plx, cam_ply;
   logic [10:0]       scr_w, scr_h;

   wall_slice_type expected_slices[$];
   int             mismatches = 0;
   bit             calm = 0;

   function automatic longint floor_div(longint a, longint b);
      longint q;
      q = a / b;
      if (a % b != 0 && a < 0) q--;
      return q;
   endfunction

   function automatic longint usable_size(logic [10:0] v);
      if (v == 0) return 1;
      if (v > 1024) return 1024;
      return v;
   endfunction

   function automatic wall_slice_type trace_column(logic [COL_W-1:0] col);
      wall_slice_type r;
      longint w, h, cam, rdx, rdy, dx, dy, px, py, mx, my, sx, sy, ax, ay;
      longint n, d, perp, lh, ds, de, tex, base, other, m, s, fr;
      int hit, side, code, k;
      n = 0; perp = 0; lh = 0; ds = 0; de = 0; tex = 0;
      hit = 0; side = 0; code = 0;
      w = usable_size(scr_w);
      h = usable_size(scr_h);
      cam = floor_div(longint'(col) * 32768, w) - 16384;
      rdx = longint'($signed(cam_dx)) + floor_div(longint'($signed(cam_plx)) * cam, 16384);
      rdy = longint'($signed(cam_dy)) + floor_div(longint'($signed(cam_ply)) * cam, 16384);
      dx = rdx < 0 ? -rdx : rdx;
      dy = rdy < 0 ? -rdy : rdy;
      px = cam_px;
      py = cam_py;
      mx = px >> 10;
      my = py >> 10;
      sx = rdx < 0 ? -1 : 1;
      sy = rdy < 0 ? -1 : 1;
      ax = rdx < 0 ? (px & 1023) : 1024 - (px & 1023);
      ay = rdy < 0 ? (py & 1023) : 1024 - (py & 1023);
      if (mx < MAP_DIM && my < MAP_DIM) begin
         for (k = 0; k < MAX_STEPS; k++) begin
            if (ax * dy < ay * dx) begin
               n = ax; ax += 1024; mx += sx; side = 0;
            end else begin
               n = ay; ay += 1024; my += sy; side = 1;
            end
            if (mx < 0 || my < 0 || mx >= MAP_DIM || my >= MAP_DIM) break;
            code = grid[my*MAP_DIM + mx];
            if (code != 0) begin
               hit = 1;
               break;
            end
         end
      end
      if (hit) begin
         d = side ? dy : dx;
         if (d == 0) begin
            perp = 65535;
            tex = 0;
         end else begin
            base = side ? px : py;
            other = side ? rdx : rdy;
            m = 1024 * d;
            s = base * d + n * other;
            fr = s - floor_div(s, m) * m;
            perp = n * 4096 / d;
            if (perp > 65535) perp = 65535;
            tex = fr * 64 / m;
            if ((side == 0 && rdx > 0) || (side == 1 && rdy < 0)) tex = 63 - tex;
         end
         lh = (perp == 0) ? 65535 : h * 256 / perp;
         if (lh > 65535) lh = 65535;
         ds = h / 2 - lh / 2;
         if (ds < 0) ds = 0;
         de = lh / 2 + h / 2;
         if (de >= h) de = h - 1;
      end else begin
         side = 0;
         code = 0;
      end
      r.column = col;
      r.hit = hit[0];
      r.side = side[0];
      r.code = code[3:0];
      r.perp = perp[15:0];
      r.height = lh[15:0];
      r.span_top = ds[9:0];
      r.span_bottom = de[9:0];
      r.tex = tex[5:0];
      return r;
   endfunction

   function automatic int idle_len();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // result side: random back-pressure
   int stall_left = 0;
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         stall_left <= idle_len();
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      wall_slice_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_out_column, rsp_hit, rsp_side, rsp_wall_code, rsp_perp_dist,
                rsp_line_height, rsp_draw_start, rsp_draw_end, rsp_tex_x};
         if (expected_slices.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transfer %p", got);
         end else begin
            want = expected_slices.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
            end
         end
      end
   end

   task automatic send_item(logic func, logic [5:0] cx, logic [5:0] cy, logic [3:0] cc,
                            logic [9:0] col);
      int gap;
      req_valid <= 1'b1;
      req_func <= func;
      req_cell_x <= cx;
      req_cell_y <= cy;
      req_cell_code <= cc;
      req_column <= col;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (func == FUNC_CAST) expected_slices.push_back(trace_column(col));
      else grid[{cy, cx}] = cc;
      gap = idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic cast(logic [9:0] col);
      send_item(FUNC_CAST, 0, 0, 0, col);
   endtask

   task automatic write_cell(int x, int y, logic [3:0] c);
      send_item(FUNC_MAP_WR, x[5:0], y[5:0], c, 0);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_slices.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [15:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_POS_X:    cam_px = v;
         CSR_POS_Y:    cam_py = v;
         CSR_DIR_X:    cam_dx = v;
         CSR_DIR_Y:    cam_dy = v;
         CSR_PLANE_X:  cam_plx = v;
         CSR_PLANE_Y:  cam_ply = v;
         CSR_SCREEN_W: scr_w = v[10:0];
         CSR_SCREEN_H: scr_h = v[10:0];
         default: ;
      endcase
   endtask

   task automatic set_camera(logic [15:0] px, logic [15:0] py, logic [15:0] dx,
                             logic [15:0] dy, logic [15:0] plx, logic [15:0] ply);
      write_reg(CSR_POS_X, px);
      write_reg(CSR_POS_Y, py);
      write_reg(CSR_DIR_X, dx);
      write_reg(CSR_DIR_Y, dy);
      write_reg(CSR_PLANE_X, plx);
      write_reg(CSR_PLANE_Y, ply);
   endtask

   task automatic test_room();
      int x, y;
      calm = 1;
      for (y = 0; y <= ROOM; y++)
         for (x = 0; x <= ROOM; x++)
            write_cell(x, y, (x == ROOM || y == ROOM) ? 4'((x + y) % 15 + 1) : 4'd0);
      calm = 0;
      // reset camera: rays leave through the low map edges or hit the far walls
      cast(0);
      cast(160);
      cast(1023);
      settle();
   endtask

   task automatic test_random_map(int density);
      int x, y;
      calm = 1;
      for (y = 0; y < ROOM; y++)
         for (x = 0; x < ROOM; x++)
            write_cell(x, y, ($urandom_range(0, 99) < density) ? 4'($urandom_range(1, 15)) : 4'd0);
      calm = 0;
      settle();
   endtask

   task automatic test_directed();
      set_camera(16'(6*1024 + 512), 16'(6*1024 + 512), 16'd16384, 16'd0, 16'd0, 16'd10813);
      cast(0);
      cast(160);
      cast(319);
      cast(1023);
      settle();
      // diagonal through cell centre: crossings tie
      set_camera(16'(6*1024 + 512), 16'(6*1024 + 512), 16'd16384, 16'd16384, 16'd0, 16'd0);
      cast(5);
      settle();
      // zero ray steps in y only, with zero divisor
      set_camera(16'(6*1024 + 512), 16'(6*1024 + 512), 16'd0, 16'd0, 16'd0, 16'd0);
      cast(7);
      settle();
      // on a cell boundary in x looking back into a wall: zero distance
      write_cell(5, 6, 4'd9);
      settle();
      set_camera(16'(6*1024), 16'(6*1024 + 300), 16'hC000, 16'd0, 16'd0, 16'd0);
      cast(0);
      settle();
      // screen size extremes and out-of-range values
      set_camera(16'(6*1024 + 100), 16'(7*1024 + 900), 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
      write_reg(CSR_SCREEN_W, 16'd1);
      write_reg(CSR_SCREEN_H, 16'd1);
      cast(0);
      cast(1023);
      settle();
      write_reg(CSR_SCREEN_W, 16'd1024);
      write_reg(CSR_SCREEN_H, 16'd1024);
      cast(0);
      cast(1023);
      cast(512);
      settle();
      write_reg(CSR_SCREEN_W, 16'd0);
      write_reg(CSR_SCREEN_H, 16'h07FF);
      cast(3);
      settle();
      write_reg(CSR_SCREEN_W, 16'hFFFF);
      write_reg(CSR_SCREEN_H, 16'd0);
      cast(700);
      settle();
   endtask

   function automatic logic [15:0] pick_vector();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 16'h8000;
      if (r == 1) return 16'h7FFF;
      if (r == 2) return 16'd0;
      if (r < 6) return 16'($urandom_range(0, 65535));
      return 16'(int'($urandom_range(0, 32768)) - 16384);
   endfunction

   task automatic test_random_views(int phases, int per_phase);
      int p, i, r;
      logic [15:0] w;
      for (p = 0; p < phases; p++) begin
         r = $urandom_range(0, 9);
         set_camera(r == 0 ? 16'd0 :
                    (r == 1 ? 16'(ROOM*1024 - 1) : 16'($urandom_range(0, ROOM*1024 - 1))),
                    r == 2 ? 16'd0 :
                    (r == 3 ? 16'(ROOM*1024 - 1) : 16'($urandom_range(0, ROOM*1024 - 1))),
                    pick_vector(), pick_vector(), pick_vector(), pick_vector());
         r = $urandom_range(0, 9);
         w = r == 0 ? 16'd1 : (r == 1 ? 16'd1024 : (r == 2 ? 16'h07FF :
             16'($urandom_range(1, 1024))));
         write_reg(CSR_SCREEN_W, w);
         r = $urandom_range(0, 9);
         write_reg(CSR_SCREEN_H, r == 0 ? 16'd1 : (r == 1 ? 16'd1024 : (r == 2 ? 16'd0 :
                   16'($urandom_range(1, 2047)))));
         calm = (p % 5 == 4);
         for (i = 0; i < per_phase; i++) begin
            if ($urandom_range(0, 99) < 20)
               write_cell($urandom_range(0, ROOM - 1), $urandom_range(0, ROOM - 1),
                          ($urandom_range(0, 2) == 0) ? 4'd0 : 4'($urandom_range(1, 15)));
            else if ($urandom_range(0, 9) == 0)
               cast(10'($urandom_range(0, 1023)));
            else
               cast(10'($urandom_range(0, int'(usable_size(w[10:0])) - 1)));
         end
         calm = 0;
         settle();
      end
   endtask

   initial begin
      cam_px = 0; cam_py = 0; cam_dx = 16384; cam_dy = 0;
      cam_plx = 0; cam_ply = 10813; scr_w = 320; scr_h = 240;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_room();
      test_directed();
      test_random_map(12);
      test_random_views(5, 80);
      test_random_map(3);
      test_random_views(4, 60);
      settle();
      repeat (50) @(posedge clock);
      if (mismatches == 0 && expected_slices.size() == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

   initial begin
      #40ms;
      $display("FAILURE");
      $finish;
   end

endmodule
